// ===== rtl/soa_pkg.sv =====
// shared types, constants and code values for the slab object allocator
package soa_pkg;

   localparam int POOL_PAGES           = 1024;
   localparam int PAGE_BYTES           = 4096;
   localparam int CLASS_SLOTS          = 16;
   localparam int OBJECTS_PER_PAGE_MAX = 128;

   localparam int PAGE_W  = 10;   // page number
   localparam int LINK_W  = 11;   // page number or no-page code
   localparam int CLS_W   = 4;
   localparam int CNT_W   = 5;    // class count, up to CLASS_SLOTS
   localparam int SIZE_W  = 13;   // object size, up to PAGE_BYTES
   localparam int INPG_W  = 12;   // byte offset inside a page
   localparam int OBJ_W   = 7;    // object index inside a page
   localparam int FREE_W  = 8;    // free object count, up to OBJECTS_PER_PAGE_MAX
   localparam int DIV_W   = 13;
   localparam int DSTEP_W = 4;

   localparam logic [LINK_W-1:0] NO_PAGE = LINK_W'(POOL_PAGES);

   localparam logic [1:0] STATUS_OK       = 2'd0;
   localparam logic [1:0] STATUS_NO_CLASS = 2'd1;
   localparam logic [1:0] STATUS_NO_PAGES = 2'd2;
   localparam logic [1:0] STATUS_IGNORED  = 2'd3;

   localparam logic OP_ALLOC = 1'b0;
   localparam logic OP_FREE  = 1'b1;

   typedef struct packed {
      logic        operation;
      logic [15:0] request_size;
      logic [21:0] free_offset;
   } soa_req_type;

   typedef struct packed {
      logic [21:0] object_offset;
      logic [1:0]  status;
   } soa_rsp_type;

   // one page descriptor as held in the page memory
   typedef struct packed {
      logic [CLS_W-1:0]                owner;
      logic [LINK_W-1:0]               next;
      logic [FREE_W-1:0]               free_cnt;
      logic [OBJECTS_PER_PAGE_MAX-1:0] bits;
   } soa_page_type;

   // reset value of the size class table
   function automatic logic [SIZE_W-1:0] default_class_size(input logic [CLS_W-1:0] idx);
      logic [SIZE_W-1:0] v;
      case (idx)
         4'd0:    v = SIZE_W'(32);
         4'd1:    v = SIZE_W'(64);
         4'd2:    v = SIZE_W'(128);
         4'd3:    v = SIZE_W'(256);
         4'd4:    v = SIZE_W'(512);
         4'd5:    v = SIZE_W'(1024);
         default: v = '0;
      endcase
      return v;
   endfunction

endpackage

// ===== rtl/soa_div.sv =====
// restoring divider, one quotient bit per cycle
module soa_div import soa_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  logic              go,
   input  logic [DIV_W-1:0]  dividend,
   input  logic [DIV_W-1:0]  divisor,
   output logic              done,
   output logic [DIV_W-1:0]  quotient
);

   logic               run_ff;
   logic               done_ff;
   logic [DSTEP_W-1:0] cnt_ff;
   logic [DIV_W-1:0]   num_ff;
   logic [DIV_W-1:0]   den_ff;
   logic [DIV_W:0]     rem_ff;
   logic [DIV_W-1:0]   q_ff;
   logic [DIV_W:0]     rem_shift;
   logic               fits;

   assign rem_shift = {rem_ff[DIV_W-1:0], num_ff[DIV_W-1]};
   assign fits      = rem_shift >= {1'b0, den_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         done_ff <= 1'b0;
         if (go) begin
            run_ff <= 1'b1;
            cnt_ff <= DSTEP_W'(DIV_W - 1);
            num_ff <= dividend;
            den_ff <= divisor;
            rem_ff <= '0;
         end else if (run_ff) begin
            rem_ff <= fits ? rem_shift - {1'b0, den_ff} : rem_shift;
            q_ff   <= {q_ff[DIV_W-2:0], fits};
            num_ff <= {num_ff[DIV_W-2:0], 1'b0};
            cnt_ff <= cnt_ff - 1'b1;
            if (cnt_ff == '0) begin
               run_ff  <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   assign done     = done_ff;
   assign quotient = q_ff;

endmodule

// ===== rtl/soa_page_ram.sv =====
// page descriptor memory, one write and one registered read port
module soa_page_ram import soa_pkg::*; (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [PAGE_W-1:0] wr_addr,
   input  soa_page_type      wr_data,
   input  logic              rd_en,
   input  logic [PAGE_W-1:0] rd_addr,
   output soa_page_type      rd_data
);

   soa_page_type mem [POOL_PAGES];
   soa_page_type rd_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_ff;

endmodule

// ===== rtl/slab_object_allocator_unit.sv =====
// top level of the slab object allocator: control sequencer, class table and result register
// A request is taken when start is high and busy is low; exactly one result follows, shown
// for one cycle with rsp_valid and never held off. Allocation searches the size class table
// one entry a cycle, divides the page size by the object size on the shared divider, then walks
// the class's page chain one page at a time through the page memory and finishes with one
// write on success. Free reads the page descriptor and runs two divisions. Pages are handed
// out in order and never returned, so page use is a fill count and the page memory needs no
// clearing pass after reset.
module slab_object_allocator_unit import soa_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  soa_req_type req_data,
   output logic        rsp_valid,
   output soa_rsp_type rsp_data
);

   typedef enum logic [3:0] {
      S_IDLE, S_FIND, S_NDIV, S_WALK, S_WCHK, S_NEWPG,
      S_FRD, S_FCAP, S_FGO, S_FIDX, S_FN, S_FCHK
   } state_type;

   state_type         state_ff;
   soa_req_type       req_ff;
   logic [CNT_W-1:0]  i_ff;
   logic [CLS_W-1:0]  cls_ff;
   logic [FREE_W-1:0] n_ff;
   logic [LINK_W-1:0] page_ff;
   logic [LINK_W-1:0] fill_ff;        // pages below this are in use
   logic [INPG_W-1:0] idx_ff;
   soa_page_type      ent_ff;
   logic [CNT_W-1:0]  count_ff;
   logic [SIZE_W-1:0] class_size_ff [CLASS_SLOTS];
   logic [LINK_W-1:0] head_ff [CLASS_SLOTS];
   logic              rsp_valid_ff;
   soa_rsp_type       rsp_ff;

   logic              div_go;
   logic [DIV_W-1:0]  div_num;
   logic [DIV_W-1:0]  div_den;
   logic              div_done;
   logic [DIV_W-1:0]  div_q;
   logic [FREE_W-1:0] n_sat;

   logic              ram_wr_en;
   logic [PAGE_W-1:0] ram_wr_addr;
   soa_page_type      ram_wr_data;
   logic              ram_rd_en;
   logic [PAGE_W-1:0] ram_rd_addr;
   soa_page_type      ram_rd;

   logic [CLS_W-1:0]  cls_rd_idx;
   logic [SIZE_W-1:0] sz_rd;
   logic [OBJ_W-1:0]  clear_pos;
   logic [19:0]       obj_prod;
   logic              free_ok;
   logic [PAGE_W-1:0] free_page;

   // one class table read port, shared between the search and the chosen class
   assign cls_rd_idx = (state_ff == S_FIND) ? i_ff[CLS_W-1:0] : cls_ff;
   assign sz_rd      = class_size_ff[cls_rd_idx];
   assign free_page  = req_ff.free_offset[21:INPG_W];

   // objects per page saturates at the bitmap width
   assign n_sat = (div_q > DIV_W'(OBJECTS_PER_PAGE_MAX)) ?
                  FREE_W'(OBJECTS_PER_PAGE_MAX) : div_q[FREE_W-1:0];

   // lowest clear object bit of the page just read
   always_comb begin
      clear_pos = '0;
      for (int b = OBJECTS_PER_PAGE_MAX - 1; b >= 0; b--) begin
         if (!ram_rd.bits[b]) begin
            clear_pos = OBJ_W'(b);
         end
      end
   end

   // in-page offset of the object, always below the page size
   assign obj_prod = clear_pos * sz_rd;

   assign free_ok = ({{(INPG_W-FREE_W){1'b0}}, n_ff} > idx_ff) && ent_ff.bits[idx_ff[OBJ_W-1:0]];

   // divider operands
   always_comb begin
      div_go  = 1'b0;
      div_num = DIV_W'(PAGE_BYTES);
      div_den = sz_rd;
      unique case (state_ff)
         S_FIND: begin
            if (i_ff < count_ff) begin
               div_go = sz_rd >= SIZE_W'(req_ff.request_size) &&
                        req_ff.request_size[15:SIZE_W] == '0;
            end else if (count_ff < CNT_W'(CLASS_SLOTS) && req_ff.request_size != '0) begin
               div_go  = 1'b1;
               div_den = req_ff.request_size[SIZE_W-1:0];
            end
         end
         S_FGO: begin
            div_go  = 1'b1;
            div_num = {1'b0, req_ff.free_offset[INPG_W-1:0]};
         end
         S_FIDX: begin
            div_go = div_done;
         end
         default: begin
         end
      endcase
   end

   // page memory access
   always_comb begin
      ram_rd_en   = 1'b0;
      ram_rd_addr = page_ff[PAGE_W-1:0];
      ram_wr_en   = 1'b0;
      ram_wr_addr = page_ff[PAGE_W-1:0];
      ram_wr_data = ram_rd;
      unique case (state_ff)
         S_WALK: begin
            ram_rd_en = page_ff != NO_PAGE;
         end
         S_FRD: begin
            ram_rd_en   = 1'b1;
            ram_rd_addr = free_page;
         end
         S_WCHK: begin
            ram_wr_en                      = ram_rd.free_cnt != '0;
            ram_wr_data.bits[clear_pos]    = 1'b1;
            ram_wr_data.free_cnt           = ram_rd.free_cnt - 1'b1;
         end
         S_NEWPG: begin
            ram_wr_en            = fill_ff < LINK_W'(POOL_PAGES);
            ram_wr_addr          = fill_ff[PAGE_W-1:0];
            ram_wr_data.owner    = cls_ff;
            ram_wr_data.next     = head_ff[cls_ff];
            ram_wr_data.free_cnt = n_ff - 1'b1;
            ram_wr_data.bits     = OBJECTS_PER_PAGE_MAX'(1);
         end
         S_FCHK: begin
            ram_wr_en                           = free_ok;
            ram_wr_addr                         = free_page;
            ram_wr_data                         = ent_ff;
            ram_wr_data.bits[idx_ff[OBJ_W-1:0]] = 1'b0;
            ram_wr_data.free_cnt                = ent_ff.free_cnt + 1'b1;
         end
         default: begin
         end
      endcase
   end

   soa_div u_div (
      .clock    (clock),
      .reset    (reset),
      .go       (div_go),
      .dividend (div_num),
      .divisor  (div_den),
      .done     (div_done),
      .quotient (div_q)
   );

   // writes are issued only at the end of a request, so no read of the next one overlaps
   soa_page_ram u_page_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
         count_ff     <= CNT_W'(6);
         fill_ff      <= '0;
         for (int c = 0; c < CLASS_SLOTS; c++) begin
            class_size_ff[c] <= default_class_size(CLS_W'(c));
            head_ff[c]       <= NO_PAGE;
         end
      end else begin
         rsp_valid_ff <= 1'b0;
         unique case (state_ff)
            S_IDLE: begin
               if (start) begin
                  req_ff <= req_data;
                  i_ff   <= '0;
                  if (req_data.operation == OP_ALLOC) begin
                     if (req_data.request_size > 16'(PAGE_BYTES)) begin
                        rsp_valid_ff <= 1'b1;
                        rsp_ff       <= '{object_offset: '0, status: STATUS_NO_CLASS};
                     end else begin
                        state_ff <= S_FIND;
                     end
                  end else if ({1'b0, req_data.free_offset[21:INPG_W]} >= fill_ff) begin
                     rsp_valid_ff <= 1'b1;
                     rsp_ff       <= '{object_offset: '0, status: STATUS_IGNORED};
                  end else begin
                     state_ff <= S_FRD;
                  end
               end
            end
            // first fitting class, else append one if the table has room and the size is nonzero, else fail
            S_FIND: begin
               if (i_ff < count_ff) begin
                  if (div_go) begin
                     cls_ff   <= i_ff[CLS_W-1:0];
                     state_ff <= S_NDIV;
                  end else begin
                     i_ff <= i_ff + 1'b1;
                  end
               end else if (div_go) begin
                  class_size_ff[count_ff[CLS_W-1:0]] <= req_ff.request_size[SIZE_W-1:0];
                  head_ff[count_ff[CLS_W-1:0]]       <= NO_PAGE;
                  count_ff                           <= count_ff + 1'b1;
                  cls_ff                             <= count_ff[CLS_W-1:0];
                  state_ff                           <= S_NDIV;
               end else begin
                  rsp_valid_ff <= 1'b1;
                  rsp_ff       <= '{object_offset: '0, status: STATUS_NO_CLASS};
                  state_ff     <= S_IDLE;
               end
            end
            S_NDIV: begin
               if (div_done) begin
                  n_ff     <= n_sat;
                  page_ff  <= head_ff[cls_ff];
                  state_ff <= S_WALK;
               end
            end
            S_WALK: begin
               state_ff <= (page_ff == NO_PAGE) ? S_NEWPG : S_WCHK;
            end
            // page descriptor is on the read port now
            S_WCHK: begin
               if (ram_rd.free_cnt != '0) begin
                  rsp_valid_ff <= 1'b1;
                  rsp_ff       <= '{object_offset: {page_ff[PAGE_W-1:0], obj_prod[INPG_W-1:0]},
                                    status: STATUS_OK};
                  state_ff     <= S_IDLE;
               end else begin
                  page_ff  <= ram_rd.next;
                  state_ff <= S_WALK;
               end
            end
            // lowest unused page, if any is left, becomes the new chain head
            S_NEWPG: begin
               rsp_valid_ff <= 1'b1;
               state_ff     <= S_IDLE;
               if (fill_ff < LINK_W'(POOL_PAGES)) begin
                  head_ff[cls_ff] <= fill_ff;
                  fill_ff         <= fill_ff + 1'b1;
                  rsp_ff          <= '{object_offset: {fill_ff[PAGE_W-1:0], {INPG_W{1'b0}}},
                                       status: STATUS_OK};
               end else begin
                  rsp_ff <= '{object_offset: '0, status: STATUS_NO_PAGES};
               end
            end
            S_FRD: begin
               state_ff <= S_FCAP;
            end
            S_FCAP: begin
               ent_ff   <= ram_rd;
               cls_ff   <= ram_rd.owner;
               state_ff <= S_FGO;
            end
            S_FGO: begin
               state_ff <= S_FIDX;
            end
            S_FIDX: begin
               if (div_done) begin
                  idx_ff   <= div_q[INPG_W-1:0];
                  state_ff <= S_FN;
               end
            end
            S_FN: begin
               if (div_done) begin
                  n_ff     <= n_sat;
                  state_ff <= S_FCHK;
               end
            end
            S_FCHK: begin
               rsp_valid_ff <= 1'b1;
               rsp_ff       <= '{object_offset: '0, status: free_ok ? STATUS_OK : STATUS_IGNORED};
               state_ff     <= S_IDLE;
            end
            default: begin
               state_ff <= S_IDLE;
            end
         endcase
      end
   end

   assign busy      = state_ff != S_IDLE;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   // a result transfer always ends the request
   a_rsp_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !busy)
      else $error("result while request still in work");

   // page fill count never passes the pool
   a_fill_range: assert property (@(posedge clock) disable iff (reset)
      fill_ff <= LINK_W'(POOL_PAGES))
      else $error("page fill count out of range");

   // failures carry a zero offset
   a_fail_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.status != STATUS_OK |-> rsp_data.object_offset == '0)
      else $error("failed request with nonzero offset");

   // class count only grows and stays within the table
   a_count: assert property (@(posedge clock) disable iff (reset)
      count_ff >= $past(count_ff) && count_ff <= CNT_W'(CLASS_SLOTS))
      else $error("class count misbehaves");

endmodule
